@@ hw/rtl/tep_pkg.sv @@
// ---------------------------------------------------------------------------
// tep_pkg
// shared codes and types of the terminal escape parser
// ---------------------------------------------------------------------------
package tep_pkg;

    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int POS_W   = 7;
    localparam int CMD_W   = 4;
    localparam int ATTR_W  = 3;
    localparam int STATE_W = 3;
    localparam int OUT_W   = 32;

    // parse states
    localparam logic [STATE_W-1:0] PS_NORMAL = 3'd0;
    localparam logic [STATE_W-1:0] PS_ESC    = 3'd1;
    localparam logic [STATE_W-1:0] PS_ROW    = 3'd2;
    localparam logic [STATE_W-1:0] PS_COL    = 3'd3;
    localparam logic [STATE_W-1:0] PS_ATTR   = 3'd4;

    // screen commands
    localparam logic [CMD_W-1:0] CMD_GLYPH    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_BS       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_TAB      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_LF       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_UP       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CR       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLR_HOME = 4'd7;
    localparam logic [CMD_W-1:0] CMD_HOME     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_NEWLINE  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_PLACE    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_EOL_ERA  = 4'd11;
    localparam logic [CMD_W-1:0] CMD_EOS_ERA  = 4'd12;
    localparam logic [CMD_W-1:0] CMD_SET_ATTR = 4'd13;

    // attribute bits
    localparam logic [ATTR_W-1:0] AT_REV   = 3'b001;
    localparam logic [ATTR_W-1:0] AT_BLINK = 3'b010;
    localparam logic [ATTR_W-1:0] AT_HALF  = 3'b100;

    // control codes
    localparam logic [BYTE_W-1:0] CC_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CC_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CC_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CC_UP    = 8'h0B;
    localparam logic [BYTE_W-1:0] CC_RIGHT = 8'h0C;
    localparam logic [BYTE_W-1:0] CC_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CC_CLEAR = 8'h1A;
    localparam logic [BYTE_W-1:0] CC_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CC_HOME  = 8'h1E;
    localparam logic [BYTE_W-1:0] CC_NL    = 8'h1F;
    localparam logic [BYTE_W-1:0] CC_SPACE = 8'h20;

    // escape and attribute characters
    localparam logic [CHAR_W-1:0] EC_ROWCOL = 7'h3D; // '='
    localparam logic [CHAR_W-1:0] EC_ATTR   = 7'h47; // 'G'
    localparam logic [CHAR_W-1:0] EC_CLR_A  = 7'h2A; // '*'
    localparam logic [CHAR_W-1:0] EC_CLR_B  = 7'h3A; // ':'
    localparam logic [CHAR_W-1:0] EC_EOL    = 7'h54; // 'T'
    localparam logic [CHAR_W-1:0] EC_EOS    = 7'h59; // 'Y'
    localparam logic [CHAR_W-1:0] EC_HALF   = 7'h26; // '&'
    localparam logic [CHAR_W-1:0] EC_FULL   = 7'h27;
    localparam logic [CHAR_W-1:0] AC_NONE   = 7'h30; // '0'
    localparam logic [CHAR_W-1:0] AC_BLINK  = 7'h32; // '2'
    localparam logic [CHAR_W-1:0] AC_REV    = 7'h34; // '4'
    localparam logic [CHAR_W-1:0] AC_BOTH   = 7'h36; // '6'
    localparam logic [POS_W-1:0]  POS_BASE  = 7'h20;

    // config register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [POS_W-1:0] ROWS_RESET = 7'd24;
    localparam logic [POS_W-1:0] COLS_RESET = 7'd80;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [POS_W-1:0]   pend_row;
        logic [ATTR_W-1:0]  attr;
    } t_parse;

    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] glyph;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [ATTR_W-1:0] attr;
    } t_result;

endpackage

@@ hw/rtl/terminal_escape_parser.sv @@
// ---------------------------------------------------------------------------
// terminal_escape_parser
// each byte is registered at the input, decoded, and its command word is registered at the output
// throughput: one byte per cycle while the output is free, set by the single decode stage
// bytes that cause no command are absorbed without an output word
// reset: synchronous active low, parser to normal, attribute cleared,
// 24 rows and 80 columns
// ---------------------------------------------------------------------------
module terminal_escape_parser
    import tep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [POS_W-1:0]  i_cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_in
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // command, glyph_code, target_row,
                                              // target_col, attribute, zero pad
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_parse            r_parse;
    logic [POS_W-1:0]  r_rows;
    logic [POS_W-1:0]  r_cols;

    t_parse            n_parse;
    t_result           n_res;
    logic              out_free;
    logic              advance;

    tep_decode u_decode (
        .i_cur  (r_parse),
        .i_byte (r_in_byte),
        .i_rows (r_rows),
        .i_cols (r_cols),
        .o_next (n_parse),
        .o_res  (n_res)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_parse     <= '0;
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_parse     <= n_parse;
                r_out_valid <= n_res.valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.attr, r_out.col, r_out.row,
                            r_out.glyph, r_out.command};

endmodule

@@ hw/rtl/tep_decode.sv @@
// ---------------------------------------------------------------------------
// tep_decode
// one byte of parse: next parser state and the screen command it causes
// ---------------------------------------------------------------------------
module tep_decode
    import tep_pkg::*;
(
    input  t_parse            i_cur,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [POS_W-1:0]  i_rows,
    input  logic [POS_W-1:0]  i_cols,
    output t_parse            o_next,
    output t_result           o_res
);

    logic [CHAR_W-1:0] v;
    logic [POS_W-1:0]  offs;
    logic              below;

    assign v     = i_byte[CHAR_W-1:0];
    assign offs  = v - POS_BASE;
    assign below = (v < POS_BASE);

    always_comb begin
        o_next = i_cur;
        o_res  = '0;
        o_next.state = PS_NORMAL;
        case (i_cur.state)
            PS_ESC: begin
                case (v)
                    EC_ROWCOL: o_next.state = PS_ROW;
                    EC_ATTR:   o_next.state = PS_ATTR;
                    EC_CLR_A, EC_CLR_B: begin
                        o_res.valid   = 1'b1;
                        o_res.command = CMD_CLR_HOME;
                    end
                    EC_EOL: begin
                        o_res.valid   = 1'b1;
                        o_res.command = CMD_EOL_ERA;
                    end
                    EC_EOS: begin
                        o_res.valid   = 1'b1;
                        o_res.command = CMD_EOS_ERA;
                    end
                    EC_HALF: begin
                        o_next.attr   = i_cur.attr | AT_HALF;
                        o_res.valid   = 1'b1;
                        o_res.command = CMD_SET_ATTR;
                    end
                    EC_FULL: begin
                        o_next.attr   = i_cur.attr & ~AT_HALF;
                        o_res.valid   = 1'b1;
                        o_res.command = CMD_SET_ATTR;
                    end
                    default: ;
                endcase
            end
            PS_ROW: begin
                if (!below && (offs < i_rows)) begin
                    o_next.pend_row = offs;
                    o_next.state    = PS_COL;
                end
            end
            PS_COL: begin
                if (!below && (offs < i_cols)) begin
                    o_res.valid   = 1'b1;
                    o_res.command = CMD_PLACE;
                    o_res.row     = i_cur.pend_row;
                    o_res.col     = offs;
                end
            end
            PS_ATTR: begin
                case (v)
                    AC_NONE:  o_next.attr = i_cur.attr & ~(AT_REV | AT_BLINK);
                    AC_BLINK: o_next.attr = (i_cur.attr & ~AT_REV) | AT_BLINK;
                    AC_REV:   o_next.attr = (i_cur.attr & ~AT_BLINK) | AT_REV;
                    AC_BOTH:  o_next.attr = i_cur.attr | AT_REV | AT_BLINK;
                    default:  ;
                endcase
                o_res.valid   = 1'b1;
                o_res.command = CMD_SET_ATTR;
            end
            default: begin
                if (i_byte >= CC_SPACE) begin
                    o_res.valid   = 1'b1;
                    o_res.command = CMD_GLYPH;
                    o_res.glyph   = v;
                end else begin
                    o_res.valid = 1'b1;
                    case (i_byte)
                        CC_BS:    o_res.command = CMD_BS;
                        CC_TAB:   o_res.command = CMD_TAB;
                        CC_LF:    o_res.command = CMD_LF;
                        CC_UP:    o_res.command = CMD_UP;
                        CC_RIGHT: o_res.command = CMD_RIGHT;
                        CC_CR:    o_res.command = CMD_CR;
                        CC_CLEAR: o_res.command = CMD_CLR_HOME;
                        CC_HOME:  o_res.command = CMD_HOME;
                        CC_NL:    o_res.command = CMD_NEWLINE;
                        CC_ESC: begin
                            o_res.valid  = 1'b0;
                            o_next.state = PS_ESC;
                        end
                        default:  o_res.valid = 1'b0;
                    endcase
                end
            end
        endcase
        o_res.attr = o_next.attr;
    end

endmodule
